FILE: sv/gcc_pkg.sv
`default_nettype none

package gcc_pkg;

  // Fixed field widths of the two channels.
  localparam int AmountW = 31;
  localparam int ValueW  = 16;
  localparam int DenomW  = 16;

  // Command codes carried in the cmd field.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_CHANGE = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic              start_new;
    logic [DenomW-1:0] new_denomination;
    logic [AmountW-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [ValueW-1:0]  coin_value;
    logic [AmountW-1:0] coin_count;
    logic [AmountW-1:0] remainder;
    logic               last;
  } out_item_t;

endpackage : gcc_pkg

`default_nettype wire

FILE: sv/gcc_divider.sv
`default_nettype none

// Restoring divider: one quotient bit per cycle, AmountW quotient bits per divide.
module gcc_divider import gcc_pkg::*; #(
  parameter int COIN_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [AmountW-1:0]   dividend_i,
  input  wire logic [COIN_BITS-1:0] divisor_i,
  output logic                      done_o,
  output logic [AmountW-1:0]        quotient_o,
  output logic [AmountW-1:0]        remainder_o
);

  localparam int StepW = $clog2(AmountW);

  logic                 busy_q;
  logic                 done_q;
  logic [StepW-1:0]     step_q;
  logic [COIN_BITS-1:0] rem_q;
  logic [AmountW-1:0]   quo_q;
  logic [COIN_BITS-1:0] dvs_q;

  logic [COIN_BITS:0]   trial;
  logic [COIN_BITS:0]   diff;
  logic                 qbit;
  logic [31:0]          rem_ext;

  // Bring down the next dividend bit and try one subtraction.
  assign trial   = {rem_q, quo_q[AmountW-1]};
  assign diff    = trial - {1'b0, dvs_q};
  assign qbit    = (trial >= {1'b0, dvs_q});
  assign rem_ext = 32'(rem_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == StepW'(AmountW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[COIN_BITS-1:0] : trial[COIN_BITS-1:0];
      quo_q <= {quo_q[AmountW-2:0], qbit};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_ext[AmountW-1:0];

endmodule : gcc_divider

`default_nettype wire

FILE: sv/greedy_coin_change_unit.sv
// A load runs a sorted insert that moves each larger entry up one slot and
// gives no result; a dropped load goes straight back to idle.
// A change transaction reads each table entry, starts the divider, waits for
// it to finish and emits one result per entry, largest coin first.
// Output stalls lengthen it; the one divider and single table read port pace it.
// Reset (asynchronous, active low) empties the table and idles the sequencer.
`default_nettype none

module greedy_coin_change_unit import gcc_pkg::*; #(
  parameter int MAX_COINS = 8,
  parameter int COIN_BITS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  // Table address width and the width of the entry count (0..MAX_COINS).
  localparam int AW   = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int CNTW = $clog2(MAX_COINS + 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_INS_RD   = 3'd1;
  localparam logic [2:0] ST_INS_CMP  = 3'd2;
  localparam logic [2:0] ST_INS_PUT  = 3'd3;
  localparam logic [2:0] ST_WALK_RD  = 3'd4;
  localparam logic [2:0] ST_WALK_DIV = 3'd5;
  localparam logic [2:0] ST_DIV_WAIT = 3'd6;
  localparam logic [2:0] ST_EMIT     = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [CNTW-1:0]      total_q, total_d;
  logic [CNTW-1:0]      idx_q, idx_d;
  logic [COIN_BITS-1:0] coin_q, coin_d;
  logic [AmountW-1:0]   count_q, count_d;
  logic [AmountW-1:0]   amount_left_q, amount_left_d;
  logic                 last_q, last_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_data_q, out_data_d;

  // The coin table is a small memory with one write and one registered read.
  logic [COIN_BITS-1:0] coin_mem [MAX_COINS];
  logic [COIN_BITS-1:0] rd_data_q;
  logic                 rd_en;
  logic                 wr_en;
  logic [COIN_BITS-1:0] wr_data;
  logic [CNTW-1:0]      idx_m1;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;

  logic                 div_start;
  logic                 div_done;
  logic [AmountW-1:0]   div_quo;
  logic [AmountW-1:0]   div_rem;

  logic [31:0]          denom_ext;
  logic [COIN_BITS-1:0] coin_in;
  logic [CNTW-1:0]      load_total;
  logic [31:0]          coin_ext;
  logic                 out_free;
  logic                 in_fire;

  // The incoming denomination is masked to the table's coin width.
  assign denom_ext = 32'(in_data_i.new_denomination);
  assign coin_in   = denom_ext[COIN_BITS-1:0];
  assign coin_ext  = 32'(coin_q);

  assign idx_m1  = idx_q - 1'b1;
  assign rd_addr = idx_m1[AW-1:0];
  assign wr_addr = idx_q[AW-1:0];

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // A start flag on a load empties the table before the insert.
  assign load_total = in_data_i.start_new ? '0 : total_q;

  gcc_divider #(
    .COIN_BITS (COIN_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (amount_left_q),
    .divisor_i   (rd_data_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d       = state_q;
    total_d       = total_q;
    idx_d         = idx_q;
    coin_d        = coin_q;
    count_d       = count_q;
    amount_left_d = amount_left_q;
    last_d        = last_q;
    out_valid_d   = out_valid_q;
    out_data_d    = out_data_q;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_data       = coin_q;
    div_start     = 1'b0;

    // The downstream side drains the output register independently.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.cmd == CMD_LOAD) begin
            total_d = load_total;
            // Zero denominations and loads into a full table are dropped.
            if ((coin_in != '0) && (load_total < CNTW'(MAX_COINS))) begin
              coin_d  = coin_in;
              idx_d   = load_total;
              state_d = (load_total == '0) ? ST_INS_PUT : ST_INS_RD;
            end
          end else begin
            amount_left_d = in_data_i.amount;
            idx_d         = total_q;
            if (total_q == '0) begin
              // An empty table reports the whole amount as the remainder.
              coin_d  = '0;
              count_d = '0;
              last_d  = 1'b1;
              state_d = ST_EMIT;
            end else begin
              state_d = ST_WALK_RD;
            end
          end
        end
      end

      ST_INS_RD: begin
        rd_en   = 1'b1;
        state_d = ST_INS_CMP;
      end

      ST_INS_CMP: begin
        wr_en = 1'b1;
        if (rd_data_q > coin_q) begin
          // Move the larger entry up one slot and keep looking lower.
          wr_data = rd_data_q;
          idx_d   = idx_m1;
          state_d = (idx_m1 == '0) ? ST_INS_PUT : ST_INS_RD;
        end else begin
          total_d = total_q + 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_INS_PUT: begin
        wr_en   = 1'b1;
        total_d = total_q + 1'b1;
        state_d = ST_IDLE;
      end

      ST_WALK_RD: begin
        rd_en   = 1'b1;
        state_d = ST_WALK_DIV;
      end

      ST_WALK_DIV: begin
        coin_d = rd_data_q;
        last_d = (idx_q == CNTW'(1));
        if (rd_data_q == '0) begin
          count_d = '0;
          state_d = ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV_WAIT;
        end
      end

      ST_DIV_WAIT: begin
        if (div_done) begin
          count_d       = div_quo;
          amount_left_d = div_rem;
          state_d       = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_data_d.coin_value = coin_ext[ValueW-1:0];
          out_data_d.coin_count = count_q;
          out_data_d.remainder  = last_q ? amount_left_q : '0;
          out_data_d.last       = last_q;
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_m1;
            state_d = ST_WALK_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      total_q       <= '0;
      idx_q         <= '0;
      amount_left_q <= '0;
      last_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      total_q       <= total_d;
      idx_q         <= idx_d;
      amount_left_q <= amount_left_d;
      last_q        <= last_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    coin_q     <= coin_d;
    count_q    <= count_d;
    out_data_q <= out_data_d;
  end

  // Table memory: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      coin_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= coin_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule : greedy_coin_change_unit

`default_nettype wire

FILE: verif/greedy_coin_change_unit_tb.sv
module greedy_coin_change_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gcc_pkg::*;

  // The table depth of the instance under test; the predictor mirrors it.
  localparam int TableDepth = 8;
  localparam logic [AmountW-1:0] AmountMax = {AmountW{1'b1}};
  localparam logic [DenomW-1:0] DenomMax = {DenomW{1'b1}};

  // Quiet time after the last expected result, long enough to cover any
  // transaction that could still be in flight.
  localparam int SettleCycles = 400;
  localparam int DrainLimit = 20000;
  localparam int TargetItems = 360;
  localparam int QuietItems = 40;

  // The scoreboard keeps its own image of the sorted denomination table and
  // turns every accepted input transaction into the list of change results
  // that it must produce, largest coin first.
  class coin_change_scoreboard;
    logic [DenomW-1:0] denoms[TableDepth];
    int unsigned fill;
    out_item_t change_q[$];
    int unsigned errors;

    function void insert_denom(logic [DenomW-1:0] coin);
      int unsigned pos;
      pos = fill;
      while (pos > 0 && denoms[pos-1] > coin) begin
        denoms[pos] = denoms[pos-1];
        pos--;
      end
      denoms[pos] = coin;
      fill++;
    endfunction

    function void note_input(in_item_t t);
      out_item_t res;
      logic [AmountW-1:0] left;
      logic [DenomW-1:0] coin;
      int unsigned i;
      if (t.cmd == CMD_LOAD) begin
        if (t.start_new) fill = 0;
        if (t.new_denomination != '0 && fill < TableDepth) insert_denom(t.new_denomination);
      end else if (fill == 0) begin
        res.coin_value = '0;
        res.coin_count = '0;
        res.remainder  = t.amount;
        res.last       = 1'b1;
        change_q.push_back(res);
      end else begin
        left = t.amount;
        for (i = fill; i > 0; i--) begin
          coin = denoms[i-1];
          res.coin_value = coin;
          res.coin_count = left / coin;
          left = left % coin;
          res.remainder = (i == 1) ? left : '0;
          res.last = (i == 1);
          change_q.push_back(res);
        end
      end
    endfunction

    function void compare_field(string name, logic [AmountW-1:0] want, logic [AmountW-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (change_q.size() == 0) begin
        $error("result with nothing pending: coin_value %0d coin_count %0d remainder %0d last %0d",
               got.coin_value, got.coin_count, got.remainder, got.last);
        errors++;
        return;
      end
      want = change_q.pop_front();
      compare_field("coin_value", AmountW'(want.coin_value), AmountW'(got.coin_value));
      compare_field("coin_count", want.coin_count, got.coin_count);
      compare_field("remainder", want.remainder, got.remainder);
      compare_field("last", AmountW'(want.last), AmountW'(got.last));
    endfunction

    function int unsigned pending();
      return change_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;

  coin_change_scoreboard sb;

  // Set for the final stretch of the run, where neither side idles.
  bit quiet = 1'b0;

  // Stimulus bookkeeping: how many transactions did real work, and how full
  // the table is from the generator's point of view.
  int unsigned effective_items = 0;
  int unsigned shadow_fill = 0;

  greedy_coin_change_unit #(
    .MAX_COINS(TableDepth),
    .COIN_BITS(DenomW)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Both handshakes are sampled on the values just before the edge, so an
  // input transaction and a result transaction on the same edge are seen in
  // a fixed order. The input goes first in case a result passes straight
  // through in the same cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    end
  end

  // The result side alternates between ready stretches and stall bursts.
  // Each pass assigns once and then waits on the clock before the next.
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Present one input transaction and hold it until the block takes it.
  // Called right after an edge; returns right after the accepting edge.
  task automatic send_item(input in_item_t item);
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Sends one transaction, sometimes after an idle burst, and keeps count of
  // the ones that insert a coin or ask for change. Other loads do not
  // count toward the length of the run.
  task automatic issue(input in_item_t item);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    send_item(item);
    if (item.cmd == CMD_CHANGE) begin
      effective_items++;
    end else begin
      if (item.start_new) shadow_fill = 0;
      if (item.new_denomination != '0 && shadow_fill < TableDepth) begin
        shadow_fill++;
        effective_items++;
      end
    end
  endtask

  // Loads carry random bits in the unused amount field so that every input
  // bit toggles; change requests likewise carry random start and coin bits.
  task automatic load(input logic start, input logic [DenomW-1:0] denom);
    in_item_t item;
    item.cmd = CMD_LOAD;
    item.start_new = start;
    item.new_denomination = denom;
    item.amount = AmountW'($urandom);
    issue(item);
  endtask

  task automatic change(input logic [AmountW-1:0] amt);
    in_item_t item;
    item.cmd = CMD_CHANGE;
    item.start_new = 1'($urandom_range(0, 1));
    item.new_denomination = DenomW'($urandom);
    item.amount = amt;
    issue(item);
  endtask

  // Drop valid and wait for every outstanding result, with a cycle bound so
  // that missing results show up as a failure rather than a hang.
  task automatic drain_results();
    int unsigned guard;
    in_valid_i <= 1'b0;
    guard = 0;
    @(posedge clk_i);
    while (sb.pending() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  function automatic logic [DenomW-1:0] pick_denom();
    logic [DenomW-1:0] d;
    case ($urandom_range(0, 5))
      0: d = DenomW'($urandom_range(1, 20));
      1: d = DenomW'($urandom_range(1, 200));
      2: d = DenomW'(1) << $urandom_range(0, DenomW - 1);
      3: d = DenomMax;
      default: d = DenomW'($urandom_range(1, 2 ** DenomW - 1));
    endcase
    return d;
  endfunction

  function automatic logic [AmountW-1:0] pick_amount();
    logic [AmountW-1:0] a;
    case ($urandom_range(0, 7))
      0: a = '0;
      1: a = AmountMax;
      2: a = AmountW'($urandom_range(0, 1000));
      3: a = AmountW'($urandom_range(0, 200000));
      default: a = AmountW'($urandom);
    endcase
    return a;
  endfunction

  initial begin
    bit pressed;
    int unsigned n;
    int unsigned k;
    sb = new();
    pressed = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Change requests on the empty table after reset give a
    // single result that hands back the whole amount.
    change('0);
    change(AmountMax);
    // A start flag with a zero coin still empties the table, then is ignored.
    load(1'b1, '0);
    // Fill the table out of order so the sorted insert has to shift entries,
    // with the smallest and largest coins and one repeated coin.
    load(1'b0, DenomMax);
    load(1'b0, 16'd1);
    load(1'b0, 16'd25);
    load(1'b0, 16'd10);
    load(1'b0, 16'd5);
    load(1'b0, 16'd10);
    load(1'b0, 16'd50);
    load(1'b0, 16'd100);
    // The table is full now, so this load must be dropped.
    load(1'b0, 16'd7);
    change(AmountMax);
    change('0);
    change(31'd187);
    // A single large coin, with one amount just below it and one equal to it.
    load(1'b1, DenomMax);
    change(31'd65534);
    change(31'd65535);
    // Empty the table again and ask for change.
    load(1'b1, '0);
    change(31'd12345);

    // Let everything settle once before the random part starts.
    drain_results();

    // Random part. Most of it builds a fresh table and then asks for change
    // a few times; the rest is zero coins, overflow loads and stray requests.
    while (effective_items < TargetItems) begin
      quiet = (effective_items >= TargetItems - QuietItems);
      if (!pressed && effective_items >= TargetItems / 2) begin
        // Hold off the sender until the block has nothing left to report.
        drain_results();
        pressed = 1'b1;
      end
      case ($urandom_range(0, 9))
        7: load(1'($urandom_range(0, 1)), '0);
        8: begin
          n = $urandom_range(1, 3);
          for (k = 0; k < n; k++) load(1'b0, pick_denom());
        end
        9: begin
          if ($urandom_range(0, 1)) load(1'b1, '0);
          change(pick_amount());
        end
        default: begin
          n = $urandom_range(1, TableDepth);
          load(1'b1, pick_denom());
          for (k = 1; k < n; k++) load(1'b0, pick_denom());
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++) change(pick_amount());
        end
      endcase
    end

    drain_results();
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    // Watch for stray results after the last expected one.
    repeat (SettleCycles) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
